[rtl/core/lkm_pkg.sv]
// ----------------------------------------------------------------------------
// lkm_pkg
// Shared types and constants of the layered keymap with sticky modifiers.
// ----------------------------------------------------------------------------
package lkm_pkg;

   localparam int ROWS   = 7;
   localparam int COLS   = 12;
   localparam int CELLS  = ROWS * COLS;
   localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;

   localparam int CODE_W   = 8;
   localparam int NUM_MODS = 4;
   localparam int MOD_W    = 2;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_NONE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CTRL  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SYM   = 3'd4;

   localparam logic [MOD_W-1:0] MOD_CTRL  = 2'd0;
   localparam logic [MOD_W-1:0] MOD_ALT   = 2'd1;
   localparam logic [MOD_W-1:0] MOD_SHIFT = 2'd2;
   localparam logic [MOD_W-1:0] MOD_SYM   = 2'd3;

   localparam logic KIND_SCAN  = 1'b0;
   localparam logic KIND_LOAD  = 1'b1;
   localparam logic LAYER_BASE = 1'b0;
   localparam logic LAYER_SYM  = 1'b1;

   localparam logic [CODE_W-1:0] RST_NONE_CODE  = 8'd0;
   localparam logic [CODE_W-1:0] RST_CTRL_CODE  = 8'd1;
   localparam logic [CODE_W-1:0] RST_ALT_CODE   = 8'd2;
   localparam logic [CODE_W-1:0] RST_SHIFT_CODE = 8'd3;
   localparam logic [CODE_W-1:0] RST_SYM_CODE   = 8'd4;

   typedef enum logic [1:0] {
      MODE_OFF,
      MODE_ONESHOT,
      MODE_LOCKED
   } mode_type;

   typedef struct packed {
      logic [CODE_W-1:0]                 none_code;
      logic [NUM_MODS-1:0][CODE_W-1:0]   mod_code;
   } cfg_type;

   typedef struct packed {
      logic [CODE_W-1:0] base_code;
      logic [CODE_W-1:0] sym_code;
      logic              in_range;
      logic              level;
      logic              rise;
      logic              last;
   } q_entry_type;

endpackage

[rtl/core/lkm_ram.sv]
// ----------------------------------------------------------------------------
// lkm_ram
// Generic single-write, single-read RAM with registered read (read-first).
// ----------------------------------------------------------------------------
module lkm_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/lkm_front.sv]
// ----------------------------------------------------------------------------
// lkm_front
// Accepts items, writes the keymap table, looks up scanned positions and
// detects press edges; pushes one queue entry per scan item.
// ----------------------------------------------------------------------------
module lkm_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_kind,
   input  logic [2:0]                        req_row,
   input  logic [3:0]                        req_col,
   input  logic                              req_key_level,
   input  logic                              req_last_of_scan,
   input  logic                              req_layer,
   input  logic [lkm_pkg::CODE_W-1:0]        req_load_code,
   input  logic [lkm_pkg::QCNT_W-1:0]        q_count,
   output logic                              push,
   output lkm_pkg::q_entry_type              push_data
);

   logic                             accept;
   logic                             scan_acc;
   logic                             load_acc;
   logic                             in_range;
   logic [lkm_pkg::CELL_W-1:0]       entry_idx;
   logic [lkm_pkg::QCNT_W:0]         used;
   logic [lkm_pkg::CODE_W-1:0]       base_rdata;
   logic [lkm_pkg::CODE_W-1:0]       sym_rdata;
   logic                             prev_rdata;
   logic                             pvld_rd;

   logic [lkm_pkg::CELLS-1:0]        prev_vld_ff, prev_vld_in;
   logic                             look_vld_ff;
   logic                             look_inr_ff;
   logic                             look_level_ff;
   logic                             look_last_ff;
   logic                             look_pvld_ff;

   assign used      = {1'b0, q_count} + (lkm_pkg::QCNT_W + 1)'(look_vld_ff);
   assign req_stall = used >= (lkm_pkg::QCNT_W + 1)'(lkm_pkg::QDEPTH);
   assign accept    = req_valid && !req_stall;
   assign scan_acc  = accept && (req_kind == lkm_pkg::KIND_SCAN);
   assign load_acc  = accept && (req_kind == lkm_pkg::KIND_LOAD);

   assign in_range  = (int'(req_row) < lkm_pkg::ROWS) && (int'(req_col) < lkm_pkg::COLS);
   assign entry_idx = lkm_pkg::CELL_W'(req_row) * lkm_pkg::CELL_W'(lkm_pkg::COLS)
                      + lkm_pkg::CELL_W'(req_col);

   lkm_ram #(.WIDTH(lkm_pkg::CODE_W), .DEPTH(lkm_pkg::CELLS)) u_base_ram (
      .clock   (clock),
      .wr_en   (load_acc && in_range && (req_layer == lkm_pkg::LAYER_BASE)),
      .wr_addr (entry_idx),
      .wr_data (req_load_code),
      .rd_en   (scan_acc && in_range),
      .rd_addr (entry_idx),
      .rd_data (base_rdata)
   );

   lkm_ram #(.WIDTH(lkm_pkg::CODE_W), .DEPTH(lkm_pkg::CELLS)) u_sym_ram (
      .clock   (clock),
      .wr_en   (load_acc && in_range && (req_layer == lkm_pkg::LAYER_SYM)),
      .wr_addr (entry_idx),
      .wr_data (req_load_code),
      .rd_en   (scan_acc && in_range),
      .rd_addr (entry_idx),
      .rd_data (sym_rdata)
   );

   lkm_ram #(.WIDTH(1), .DEPTH(lkm_pkg::CELLS)) u_prev_ram (
      .clock   (clock),
      .wr_en   (scan_acc && in_range),
      .wr_addr (entry_idx),
      .wr_data (req_key_level),
      .rd_en   (scan_acc && in_range),
      .rd_addr (entry_idx),
      .rd_data (prev_rdata)
   );

   always_comb begin
      prev_vld_in = prev_vld_ff;
      pvld_rd     = 1'b0;
      if (in_range) begin
         pvld_rd = prev_vld_ff[entry_idx];
      end
      if (scan_acc && in_range) begin
         prev_vld_in[entry_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_vld_ff <= '0;
         look_vld_ff <= 1'b0;
      end else begin
         prev_vld_ff <= prev_vld_in;
         look_vld_ff <= scan_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (scan_acc) begin
         look_inr_ff   <= in_range;
         look_level_ff <= req_key_level;
         look_last_ff  <= req_last_of_scan;
         look_pvld_ff  <= pvld_rd;
      end
   end

   assign push                = look_vld_ff;
   assign push_data.base_code = base_rdata;
   assign push_data.sym_code  = sym_rdata;
   assign push_data.in_range  = look_inr_ff;
   assign push_data.level     = look_level_ff;
   assign push_data.rise      = look_level_ff && !(look_pvld_ff && prev_rdata);
   assign push_data.last      = look_last_ff;

endmodule

[rtl/core/lkm_queue.sv]
// ----------------------------------------------------------------------------
// lkm_queue
// Short FIFO between lookup and modifier processing.
// ----------------------------------------------------------------------------
module lkm_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  lkm_pkg::q_entry_type        push_data,
   input  logic                        pop,
   output logic                        head_valid,
   output lkm_pkg::q_entry_type        head,
   output logic [lkm_pkg::QCNT_W-1:0]  count
);

   lkm_pkg::q_entry_type             q_ff [lkm_pkg::QDEPTH];
   logic [lkm_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [lkm_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [lkm_pkg::QCNT_W-1:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_valid = count_ff != '0;
   assign head       = q_ff[rd_ptr_ff];
   assign count      = count_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != lkm_pkg::QCNT_W'(lkm_pkg::QDEPTH)) || pop)
      else $error("queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue underflow");

endmodule

[rtl/core/lkm_back.sv]
// ----------------------------------------------------------------------------
// lkm_back
// Resolves the layer, steps the sticky modifiers and registers each result.
// ----------------------------------------------------------------------------
module lkm_back (
   input  logic                              clock,
   input  logic                              reset,
   input  lkm_pkg::cfg_type                  cfg,
   input  logic                              head_valid,
   input  lkm_pkg::q_entry_type              head,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [lkm_pkg::CODE_W-1:0]        rsp_key_code,
   output logic                              rsp_key_down,
   output logic                              rsp_is_modifier,
   output logic [lkm_pkg::NUM_MODS-1:0]      rsp_mod_active,
   output logic                              rsp_scan_done
);

   lkm_pkg::mode_type                mode_ff [lkm_pkg::NUM_MODS];
   lkm_pkg::mode_type                mode_in [lkm_pkg::NUM_MODS];
   logic                             plain_ff, plain_in;
   logic                             rsp_vld_ff;
   logic [lkm_pkg::CODE_W-1:0]       code_ff;
   logic                             down_ff;
   logic                             is_mod_ff;
   logic [lkm_pkg::NUM_MODS-1:0]     active_ff;
   logic                             done_ff;

   logic [lkm_pkg::CODE_W-1:0]       key;
   logic                             emit;
   logic                             is_mod;
   logic [lkm_pkg::MOD_W-1:0]        mod_idx;
   logic                             down;
   logic [lkm_pkg::NUM_MODS-1:0]     active;

   function automatic lkm_pkg::mode_type step_mode(input lkm_pkg::mode_type m);
      lkm_pkg::mode_type r;
      unique case (m)
         lkm_pkg::MODE_OFF:     r = lkm_pkg::MODE_ONESHOT;
         lkm_pkg::MODE_ONESHOT: r = lkm_pkg::MODE_LOCKED;
         default:               r = lkm_pkg::MODE_OFF;
      endcase
      return r;
   endfunction

   assign pop = head_valid && (!rsp_vld_ff || !rsp_stall);

   always_comb begin
      key = head.base_code;
      if (mode_ff[lkm_pkg::MOD_SYM] != lkm_pkg::MODE_OFF && head.sym_code != cfg.none_code) begin
         key = head.sym_code;
      end
      emit    = head.in_range && (key != cfg.none_code);
      is_mod  = 1'b0;
      mod_idx = lkm_pkg::MOD_CTRL;
      for (int i = lkm_pkg::NUM_MODS - 1; i >= 0; i--) begin
         if (key == cfg.mod_code[i]) begin
            is_mod  = 1'b1;
            mod_idx = lkm_pkg::MOD_W'(i);
         end
      end
      mode_in  = mode_ff;
      plain_in = plain_ff;
      down     = head.level;
      if (pop && emit) begin
         if (is_mod) begin
            if (head.rise) begin
               mode_in[mod_idx] = step_mode(mode_ff[mod_idx]);
            end
            down = mode_in[mod_idx] != lkm_pkg::MODE_OFF;
         end else if (head.level) begin
            plain_in = 1'b1;
         end
      end
      if (pop && head.last) begin
         if (plain_in) begin
            for (int i = 0; i < lkm_pkg::NUM_MODS; i++) begin
               if (mode_in[i] == lkm_pkg::MODE_ONESHOT) begin
                  mode_in[i] = lkm_pkg::MODE_OFF;
               end
            end
         end
         plain_in = 1'b0;
      end
      for (int i = 0; i < lkm_pkg::NUM_MODS; i++) begin
         active[i] = mode_in[i] != lkm_pkg::MODE_OFF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < lkm_pkg::NUM_MODS; i++) begin
            mode_ff[i] <= lkm_pkg::MODE_OFF;
         end
         plain_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         plain_ff <= plain_in;
         if (pop && emit) begin
            rsp_vld_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         code_ff   <= key;
         down_ff   <= down;
         is_mod_ff <= is_mod;
         active_ff <= active;
         done_ff   <= head.last;
      end
   end

   assign rsp_valid       = rsp_vld_ff;
   assign rsp_key_code    = code_ff;
   assign rsp_key_down    = down_ff;
   assign rsp_is_modifier = is_mod_ff;
   assign rsp_mod_active  = active_ff;
   assign rsp_scan_done   = done_ff;

   a_scan_end_clears: assert property (@(posedge clock) disable iff (reset)
      pop && head.last |=> !plain_ff)
      else $error("plain key flag survives end of scan");

   a_mod_down_active: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && is_mod_ff && down_ff && !done_ff |-> active_ff != '0)
      else $error("modifier down with no active modifier");

endmodule

[rtl/core/layered_keymap_sticky_modifiers_unit.sv]
// ----------------------------------------------------------------------------
// layered_keymap_sticky_modifiers_unit
// Two-layer keymap with four sticky modifiers (off, one-shot, locked).
//
// Request beats either load one keymap entry (req_kind high) or carry one
// scanned matrix position (req_kind low), with req_last_of_scan on the final
// position of a scan. Load beats give no response. A scan beat whose
// position resolves to a key code gives one response beat; empty and
// out-of-range positions give none.
// A taken request beat passes the lookup stage, the queue and the response
// register before rsp_valid rises. Throughput: one beat per cycle while
// rsp_stall is low, set by the single modifier-update step in the back end,
// which resolves each position with the symbol mode left by the beat before.
// A four-entry queue sits between lookup and modifier logic; req_stall rises
// when the queue plus the lookup stage hold four beats, so a stalled
// response side fills the queue before requests are held off.
// Reset clears press history and modifiers at once (no clearing pass); the
// keymap table is undefined until loaded. Write CSRs only while the block
// is idle.
// ----------------------------------------------------------------------------
module layered_keymap_sticky_modifiers_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_kind,
   input  logic [2:0]                           req_row,
   input  logic [3:0]                           req_col,
   input  logic                                 req_key_level,
   input  logic                                 req_last_of_scan,
   input  logic                                 req_layer,
   input  logic [lkm_pkg::CODE_W-1:0]           req_load_code,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [lkm_pkg::CODE_W-1:0]           rsp_key_code,
   output logic                                 rsp_key_down,
   output logic                                 rsp_is_modifier,
   output logic [lkm_pkg::NUM_MODS-1:0]         rsp_mod_active,
   output logic                                 rsp_scan_done,
   input  logic                                 csr_wr_en,
   input  logic [lkm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [lkm_pkg::CODE_W-1:0]           csr_wdata
);

   lkm_pkg::cfg_type                 cfg_ff, cfg_in;
   logic                             push;
   lkm_pkg::q_entry_type             push_data;
   logic                             pop;
   logic                             head_valid;
   lkm_pkg::q_entry_type             head;
   logic [lkm_pkg::QCNT_W-1:0]       q_count;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            lkm_pkg::CSR_NONE:  cfg_in.none_code = csr_wdata;
            lkm_pkg::CSR_CTRL:  cfg_in.mod_code[lkm_pkg::MOD_CTRL] = csr_wdata;
            lkm_pkg::CSR_ALT:   cfg_in.mod_code[lkm_pkg::MOD_ALT] = csr_wdata;
            lkm_pkg::CSR_SHIFT: cfg_in.mod_code[lkm_pkg::MOD_SHIFT] = csr_wdata;
            lkm_pkg::CSR_SYM:   cfg_in.mod_code[lkm_pkg::MOD_SYM] = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.none_code                   <= lkm_pkg::RST_NONE_CODE;
         cfg_ff.mod_code[lkm_pkg::MOD_CTRL]  <= lkm_pkg::RST_CTRL_CODE;
         cfg_ff.mod_code[lkm_pkg::MOD_ALT]   <= lkm_pkg::RST_ALT_CODE;
         cfg_ff.mod_code[lkm_pkg::MOD_SHIFT] <= lkm_pkg::RST_SHIFT_CODE;
         cfg_ff.mod_code[lkm_pkg::MOD_SYM]   <= lkm_pkg::RST_SYM_CODE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lkm_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_row          (req_row),
      .req_col          (req_col),
      .req_key_level    (req_key_level),
      .req_last_of_scan (req_last_of_scan),
      .req_layer        (req_layer),
      .req_load_code    (req_load_code),
      .q_count          (q_count),
      .push             (push),
      .push_data        (push_data)
   );

   lkm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head),
      .count      (q_count)
   );

   lkm_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .head_valid      (head_valid),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_key_code    (rsp_key_code),
      .rsp_key_down    (rsp_key_down),
      .rsp_is_modifier (rsp_is_modifier),
      .rsp_mod_active  (rsp_mod_active),
      .rsp_scan_done   (rsp_scan_done)
   );

endmodule
